/* rtl/core/grid_jump_point_detect_assert.svh */
// Assertion macros shared by the jump point detector RTL.
`ifndef GRID_JUMP_POINT_DETECT_ASSERT_SVH
`define GRID_JUMP_POINT_DETECT_ASSERT_SVH

// Condition holds at every clock edge out of reset.
`define GJP_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define GJP_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define GJP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/gjp_pkg.sv */
// Shared types, constants and the width mask function of the jump point detector.
package gjp_pkg;

    localparam int MAX_WIDTH = 64;
    localparam int ROW_W     = 64;
    localparam int CFG_W     = 7;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [ROW_W-1:0] ALL_BLOCKED = {ROW_W{1'b1}};

    // Register word indexes
    localparam logic REG_GRID_WIDTH = 1'b0;

    localparam logic [CFG_W-1:0] GRID_WIDTH_RESET = CFG_W'(MAX_WIDTH);

    // Rows needed to form one result
    typedef struct packed {
        logic [ROW_W-1:0] below;
        logic [ROW_W-1:0] cur;
        logic [ROW_W-1:0] above;
        logic             done;
    } calc_req_t;

    // One result word
    typedef struct packed {
        logic [ROW_W-1:0] left;
        logic [ROW_W-1:0] down;
        logic [ROW_W-1:0] right;
        logic [ROW_W-1:0] up;
        logic             done;
    } result_t;

    // Mask of tiles in use for a given width setting
    function automatic logic [ROW_W-1:0] width_mask(input logic [CFG_W-1:0] n);
        logic [CFG_W-1:0] eff;
        logic [ROW_W-1:0] m;
        eff = (n > CFG_W'(MAX_WIDTH)) ? CFG_W'(MAX_WIDTH) : n;
        if (eff >= CFG_W'(ROW_W))
        begin
            m = ALL_BLOCKED;
        end
        else
        begin
            m = (ROW_W'(1) << eff[5:0]) - ROW_W'(1);
        end
        return m;
    endfunction

endpackage

/* rtl/core/gjp_flag_calc.sv */
// Direction flag logic for one row from its open-tile masks and its neighbors.
module gjp_flag_calc
    import gjp_pkg::*;
(
    input  calc_req_t        req,
    input  logic [CFG_W-1:0] grid_width,
    output result_t          res
);

    logic [ROW_W-1:0] w;
    logic [ROW_W-1:0] c;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] a;

    // >> 1 brings the tile at x+1 to x, << 1 the tile at x-1
    always_comb
    begin
        w = width_mask(grid_width);
        c = ~req.cur & w;
        b = ~req.below & w;
        a = ~req.above & w;
        res.up    = c & b & (((c >> 1) & ~(b >> 1)) | ((c << 1) & ~(b << 1)));
        res.right = c & (c << 1) & ((a & ~(a << 1)) | (b & ~(b << 1)));
        res.down  = c & a & (((c << 1) & ~(a << 1)) | ((c >> 1) & ~(a >> 1)));
        res.left  = c & (c >> 1) & ((b & ~(b >> 1)) | (a & ~(a >> 1)));
        res.done  = req.done;
    end

endmodule

/* rtl/core/gjp_row_track.sv */
// Row history and result issue control: holds the pending row and the row below it.
module gjp_row_track
    import gjp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [ROW_W-1:0] in_row,
    input  logic             in_last,
    output logic             issue_valid,
    input  logic             issue_ready,
    output calc_req_t        issue_req
);

    `include "grid_jump_point_detect_assert.svh"

    logic [ROW_W-1:0] waiting_reg;
    logic [ROW_W-1:0] waiting_next;
    logic [ROW_W-1:0] under_reg;
    logic [ROW_W-1:0] under_next;
    logic             pend_reg;
    logic             pend_next;
    logic             flush_reg;
    logic             flush_next;
    logic             accept;

    assign in_ready = !flush_reg && issue_ready;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        issue_valid  = flush_reg || (accept && (pend_reg || in_last));
        waiting_next = waiting_reg;
        under_next   = under_reg;
        pend_next    = pend_reg;
        flush_next   = flush_reg;

        priority if (flush_reg)
        begin
            issue_req = '{below: under_reg, cur: waiting_reg, above: ALL_BLOCKED, done: 1'b1};
        end
        else if (pend_reg)
        begin
            issue_req = '{below: under_reg, cur: waiting_reg, above: in_row, done: 1'b0};
        end
        else
        begin
            issue_req = '{below: under_reg, cur: in_row, above: ALL_BLOCKED, done: 1'b1};
        end

        if (flush_reg)
        begin
            // final row sent: back to an empty grid
            if (issue_ready)
            begin
                waiting_next = ALL_BLOCKED;
                under_next   = ALL_BLOCKED;
                pend_next    = 1'b0;
                flush_next   = 1'b0;
            end
        end
        else if (accept)
        begin
            if (in_last && !pend_reg)
            begin
                // lone final row goes out at once; state stays empty
                waiting_next = ALL_BLOCKED;
                under_next   = ALL_BLOCKED;
                pend_next    = 1'b0;
            end
            else
            begin
                if (pend_reg)
                begin
                    under_next = waiting_reg;
                end
                waiting_next = in_row;
                pend_next    = 1'b1;
                // final row after a pending one needs a second word
                flush_next   = in_last;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waiting_reg <= ALL_BLOCKED;
            under_reg   <= ALL_BLOCKED;
            pend_reg    <= 1'b0;
            flush_reg   <= 1'b0;
        end
        else
        begin
            waiting_reg <= waiting_next;
            under_reg   <= under_next;
            pend_reg    <= pend_next;
            flush_reg   <= flush_next;
        end
    end

    `GJP_ASSERT_IMPL(a_flush_has_row, flush_reg, pend_reg, "flush without a pending row")
    `GJP_ASSERT_IMPL(a_flush_blocks_input, flush_reg, !in_ready, "input taken during flush")
    `GJP_ASSERT_IMPL(a_empty_is_blocked, !pend_reg,
        (waiting_reg == ALL_BLOCKED) && (under_reg == ALL_BLOCKED),
        "empty grid state holds stale rows")

endmodule

/* rtl/core/gjp_out_skid.sv */
// Result output register with a skid stage toward the master-side stream.
module gjp_out_skid
    import gjp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  result_t in_res,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    `include "grid_jump_point_detect_assert.svh"

    result_t out_reg;
    result_t out_next;
    result_t skid_reg;
    result_t skid_next;
    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_reg;

    always_comb
    begin
        out_next        = out_reg;
        skid_next       = skid_reg;
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_next       = in_res;
                out_valid_next = in_valid;
            end
        end
        else if (in_valid && !skid_valid_reg)
        begin
            // output stalled: park the word
            skid_next       = in_res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    `GJP_ASSERT_IMPL(a_skid_behind_out, skid_valid_reg, out_valid_reg, "skid full, output empty")
    `GJP_ASSERT_NEXT(a_skid_on_stall, !skid_valid_reg && in_valid && out_valid_reg && !out_ready,
        skid_valid_reg, "stalled word not parked")

endmodule

/* rtl/core/grid_jump_point_detect.sv */
// Top level of the grid jump point detector: config register, row tracking, flags, output.
//
//  channel   | dir | handshake             | contents
//  s_*       | in  | s_tvalid / s_tready   | tdata row_blocked, tlast final_row
//  m_*       | out | m_tvalid / m_tready   | tdata up/right/down/left flags, tlast grid_done
//  APB       | in  | psel, penable, pready | grid_width at byte address 0
//
// One row word per cycle while s_tready is high; a row's flags are registered once the row
// above is taken. A final row after a pending row yields two words and holds s_tready low
// while the second one is formed; the row tracker issues one word a cycle while issue_ready
// is high. Reset clears the row history to all blocked and sets grid_width to 64.
// A stall on m_tready is absorbed by a one-word skid stage before s_tready drops.
module grid_jump_point_detect
    import gjp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [ROW_W-1:0]  s_tdata,   // [63:0] row_blocked
    input  logic              s_tlast,   // final_row
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [4*ROW_W-1:0] m_tdata,  // [63:0] up, [127:64] right, [191:128] down,
                                         // [255:192] left
    output logic              m_tlast,   // grid_done
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    logic [CFG_W-1:0] grid_width_reg;
    logic [CFG_W-1:0] grid_width_next;
    logic             cfg_write;
    logic             issue_valid;
    logic             issue_ready;
    calc_req_t        issue_req;
    result_t          calc_res;
    result_t          out_res;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        grid_width_next = grid_width_reg;
        if (cfg_write && (paddr[2] == REG_GRID_WIDTH))
        begin
            grid_width_next = pwdata[CFG_W-1:0];
        end
        prdata = '0;
        if (paddr[2] == REG_GRID_WIDTH)
        begin
            prdata = DATA_W'(grid_width_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= GRID_WIDTH_RESET;
        end
        else
        begin
            grid_width_reg <= grid_width_next;
        end
    end

    gjp_row_track u_track (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_row      (s_tdata),
        .in_last     (s_tlast),
        .issue_valid (issue_valid),
        .issue_ready (issue_ready),
        .issue_req   (issue_req)
    );

    gjp_flag_calc u_calc (
        .req        (issue_req),
        .grid_width (grid_width_reg),
        .res        (calc_res)
    );

    gjp_out_skid u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (issue_valid),
        .in_ready  (issue_ready),
        .in_res    (calc_res),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.left, out_res.down, out_res.right, out_res.up};
    assign m_tlast = out_res.done;

endmodule
